### rtl/core/sctu_pkg.sv
// ----------------------------------------------------------------------------
// sctu_pkg
// Shared constants, types and multiply helpers for the sine/cosine/tangent core.
// ----------------------------------------------------------------------------
package sctu_pkg;

    localparam int SERIES_TERMS_DEF = 19;
    localparam int ANGLE_FRAC_DEF   = 16;
    localparam int RESULT_FRAC_DEF  = 30;

    localparam int RED_FB = 32;
    localparam int SER_FB = 56;

    localparam logic [34:0] TWO_PI_RED = 35'd26986075409;
    localparam logic [34:0] PI_RED     = 35'd13493037705;
    localparam logic [63:0] COS_EPS    = 64'd7205760;

    localparam int VAL_W = 48;
    localparam int QUO_W = VAL_W - 1;
    localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {QUO_W{1'b1}}};
    localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {QUO_W{1'b0}}};

    localparam int OP_W = 2;
    localparam logic [OP_W-1:0] OP_SIN = 2'd0;
    localparam logic [OP_W-1:0] OP_COS = 2'd1;
    localparam logic [OP_W-1:0] OP_TAN = 2'd2;

    localparam int MAG_W = 63;
    localparam int SUM_W = 64;
    localparam int LANE_SIN = 0;
    localparam int LANE_COS = 1;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
        logic [SUM_W-1:0] sum;
    } sctu_lane_t;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [MAG_W-1:0] x2;
        sctu_lane_t [1:0] lane;
    } sctu_ser_t;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             sat;
    } sctu_res_t;

    typedef struct packed {
        logic [63:0] p11;
        logic [63:0] p10;
        logic [63:0] p01;
        logic [63:0] p00;
    } sctu_pp_t;

    // 64x64 product split into four 32x32 partial products
    function automatic sctu_pp_t mul_parts(logic [63:0] a, logic [63:0] b);
        sctu_pp_t pp;
        pp.p00 = 64'(a[31:0])  * 64'(b[31:0]);
        pp.p01 = 64'(a[31:0])  * 64'(b[63:32]);
        pp.p10 = 64'(a[63:32]) * 64'(b[31:0]);
        pp.p11 = 64'(a[63:32]) * 64'(b[63:32]);
        return pp;
    endfunction

    function automatic logic [127:0] mul_join(sctu_pp_t pp);
        return {64'h0, pp.p00} + ({64'h0, pp.p01} << 32) + ({64'h0, pp.p10} << 32)
            + {pp.p11, 64'h0};
    endfunction

endpackage

### rtl/core/sctu_reduce.sv
// ----------------------------------------------------------------------------
// sctu_reduce
// Angle reduction modulo 2*pi, one quotient bit per stage, then wrap to [-pi, pi].
// ----------------------------------------------------------------------------
module sctu_reduce #(
    parameter int ANGLE_FRAC_BITS = sctu_pkg::ANGLE_FRAC_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       adv,
    input  logic                       in_valid,
    input  logic [sctu_pkg::OP_W-1:0]  in_op,
    input  logic signed [31:0]         in_angle,
    output logic                       out_valid,
    output logic [sctu_pkg::OP_W-1:0]  out_op,
    output logic signed [63:0]         out_x
);
    import sctu_pkg::*;

    localparam int MW   = 64 - ANGLE_FRAC_BITS;
    localparam int QB   = 29 - ANGLE_FRAC_BITS;
    localparam int RW   = 38;
    localparam int LAST = QB + 1;
    localparam logic [MW-1:0] TP_EXT = MW'(TWO_PI_RED);
    localparam logic signed [RW-1:0] TP_S = RW'(TWO_PI_RED);
    localparam logic signed [RW-1:0] PI_S = RW'(PI_RED);

    logic [LAST:0]   v_reg;
    logic [MW-1:0]   m_reg   [QB+1];
    logic            neg_reg [QB+1];
    logic [OP_W-1:0] op_reg  [QB+1];
    logic [MW-1:0]   m_next  [QB+1];
    logic [31:0]     a_mag;
    logic signed [RW-1:0] mw, r0, r1, r2;
    logic signed [63:0] x_next, x_reg;
    logic [OP_W-1:0] xop_reg;

    always_comb begin
        logic [MW-1:0] sub;
        a_mag = in_angle[31] ? 32'(-in_angle) : 32'(in_angle);
        m_next[0] = MW'(a_mag) << (RED_FB - ANGLE_FRAC_BITS);
        for (int j = 1; j <= QB; j++) begin
            sub = TP_EXT << (QB - j);
            m_next[j] = (m_reg[j-1] >= sub) ? m_reg[j-1] - sub : m_reg[j-1];
        end
    end

    always_comb begin
        mw = {{(RW-35){1'b0}}, m_reg[QB][34:0]};
        r0 = neg_reg[QB] ? -mw : mw;
        r1 = (r0 > PI_S) ? r0 - TP_S : r0;
        r2 = (r1 < -PI_S) ? r1 + TP_S : r1;
        x_next = 64'(r2) <<< (SER_FB - RED_FB);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[LAST-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_reg[0]   <= m_next[0];
            neg_reg[0] <= in_angle[31];
            op_reg[0]  <= in_op;
            for (int j = 1; j <= QB; j++) begin
                m_reg[j]   <= m_next[j];
                neg_reg[j] <= neg_reg[j-1];
                op_reg[j]  <= op_reg[j-1];
            end
            x_reg   <= x_next;
            xop_reg <= op_reg[QB];
        end
    end

    assign out_valid = v_reg[LAST];
    assign out_op    = xop_reg;
    assign out_x     = x_reg;

endmodule

### rtl/core/sctu_term.sv
// ----------------------------------------------------------------------------
// sctu_term
// One series term for the sine and cosine lanes: multiply by x^2, divide by
// the term constant through a reciprocal with one correction, accumulate.
// ----------------------------------------------------------------------------
module sctu_term #(
    parameter int N = 1
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                adv,
    input  logic                in_valid,
    input  sctu_pkg::sctu_ser_t in_ser,
    output logic                out_valid,
    output sctu_pkg::sctu_ser_t out_ser
);
    import sctu_pkg::*;

    localparam int D_W   = 12;
    localparam int D_SIN = (2 * N) * (2 * N + 1);
    localparam int D_COS = (2 * N - 1) * (2 * N);
    localparam logic [1:0][D_W-1:0] D_L = {D_W'(D_COS), D_W'(D_SIN)};
    localparam logic [1:0][63:0] RCP = {
        64'hFFFF_FFFF_FFFF_FFFF / 64'(D_COS),
        64'hFFFF_FFFF_FFFF_FFFF / 64'(D_SIN)
    };

    logic [5:0]       v_reg;
    sctu_ser_t        ser_reg [6];
    sctu_pp_t         pp1_reg [2];
    sctu_pp_t         pp3_reg [2];
    logic [MAG_W-1:0] p2_reg  [2];
    logic [MAG_W-1:0] p3_reg  [2];
    logic [MAG_W-1:0] p4_reg  [2];
    logic [MAG_W-1:0] p5_reg  [2];
    logic [MAG_W-1:0] q4_reg  [2];
    logic [MAG_W-1:0] q5_reg  [2];
    logic [MAG_W-1:0] qd5_reg [2];

    logic [127:0]     prod2   [2];
    logic [127:0]     prod4   [2];
    logic [74:0]      qd_full [2];
    logic [MAG_W-1:0] rem6    [2];
    logic [MAG_W-1:0] q6      [2];
    sctu_ser_t        ser6_next;

    always_comb begin
        ser6_next = ser_reg[4];
        for (int l = 0; l < 2; l++) begin
            prod2[l]   = mul_join(pp1_reg[l]);
            prod4[l]   = mul_join(pp3_reg[l]);
            qd_full[l] = 75'(q4_reg[l]) * 75'(D_L[l]);
            rem6[l]    = p5_reg[l] - qd5_reg[l];
            // estimate is low by at most one
            q6[l]      = (rem6[l] >= MAG_W'(D_L[l])) ? q5_reg[l] + 1'b1 : q5_reg[l];
            ser6_next.lane[l].neg = !ser_reg[4].lane[l].neg;
            ser6_next.lane[l].mag = q6[l];
            ser6_next.lane[l].sum = ser_reg[4].lane[l].neg ?
                ser_reg[4].lane[l].sum + SUM_W'(q6[l]) :
                ser_reg[4].lane[l].sum - SUM_W'(q6[l]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ser_reg[0] <= in_ser;
            ser_reg[1] <= ser_reg[0];
            ser_reg[2] <= ser_reg[1];
            ser_reg[3] <= ser_reg[2];
            ser_reg[4] <= ser_reg[3];
            ser_reg[5] <= ser6_next;
            for (int l = 0; l < 2; l++) begin
                pp1_reg[l] <= mul_parts(64'(in_ser.lane[l].mag), 64'(in_ser.x2));
                p2_reg[l]  <= prod2[l][118:56];
                pp3_reg[l] <= mul_parts(64'(p2_reg[l]), RCP[l]);
                p3_reg[l]  <= p2_reg[l];
                p4_reg[l]  <= p3_reg[l];
                q4_reg[l]  <= prod4[l][126:64];
                p5_reg[l]  <= p4_reg[l];
                q5_reg[l]  <= q4_reg[l];
                qd5_reg[l] <= qd_full[l][MAG_W-1:0];
            end
        end
    end

    assign out_valid = v_reg[5];
    assign out_ser   = ser_reg[5];

endmodule

### rtl/core/sctu_series.sv
// ----------------------------------------------------------------------------
// sctu_series
// Forms x^2, seeds the sine and cosine lanes and runs the term stages.
// ----------------------------------------------------------------------------
module sctu_series #(
    parameter int SERIES_TERMS = sctu_pkg::SERIES_TERMS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      adv,
    input  logic                      in_valid,
    input  logic [sctu_pkg::OP_W-1:0] in_op,
    input  logic signed [63:0]        in_x,
    output logic                      out_valid,
    output sctu_pkg::sctu_ser_t       out_ser
);
    import sctu_pkg::*;

    logic [1:0]       v_reg;
    logic [OP_W-1:0]  opa_reg;
    logic [63:0]      xa_reg;
    sctu_pp_t         ppa_reg;
    sctu_ser_t        serb_reg;
    logic [63:0]      x_mag;
    logic [63:0]      xa_mag;
    logic [127:0]     x2_full;
    sctu_ser_t        serb_next;

    sctu_ser_t         ser_chain [SERIES_TERMS+1];
    logic [SERIES_TERMS:0] v_chain;

    always_comb begin
        x_mag   = in_x[63] ? 64'(-in_x) : 64'(in_x);
        xa_mag  = xa_reg[63] ? -xa_reg : xa_reg;
        x2_full = mul_join(ppa_reg);
        serb_next.op = opa_reg;
        serb_next.x2 = x2_full[118:56];
        serb_next.lane[LANE_SIN].neg = xa_reg[63];
        serb_next.lane[LANE_SIN].mag = xa_mag[MAG_W-1:0];
        serb_next.lane[LANE_SIN].sum = xa_reg;
        serb_next.lane[LANE_COS].neg = 1'b0;
        serb_next.lane[LANE_COS].mag = MAG_W'(1) << SER_FB;
        serb_next.lane[LANE_COS].sum = SUM_W'(1) << SER_FB;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            opa_reg  <= in_op;
            xa_reg   <= in_x;
            ppa_reg  <= mul_parts(x_mag, x_mag);
            serb_reg <= serb_next;
        end
    end

    assign ser_chain[0] = serb_reg;
    assign v_chain[0]   = v_reg[1];

    for (genvar n = 1; n <= SERIES_TERMS; n++) begin : g_term
        sctu_term #(
            .N (n)
        ) u_term (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_valid  (v_chain[n-1]),
            .in_ser    (ser_chain[n-1]),
            .out_valid (v_chain[n]),
            .out_ser   (ser_chain[n])
        );
    end

    assign out_valid = v_chain[SERIES_TERMS];
    assign out_ser   = ser_chain[SERIES_TERMS];

endmodule

### rtl/core/sctu_tan.sv
// ----------------------------------------------------------------------------
// sctu_tan
// Output scaling for sine and cosine, and the tangent quotient: overflow and
// near-zero checks, then one restoring quotient bit per stage.
// ----------------------------------------------------------------------------
module sctu_tan #(
    parameter int RESULT_FRAC_BITS = sctu_pkg::RESULT_FRAC_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                adv,
    input  logic                in_valid,
    input  sctu_pkg::sctu_ser_t in_ser,
    output logic                out_valid,
    output sctu_pkg::sctu_res_t out_res
);
    import sctu_pkg::*;

    localparam int TW = 64 + QUO_W;

    logic [QUO_W+1:0]  v_reg;
    logic [OP_W-1:0]   op_reg   [QUO_W+1];
    logic              neg_reg  [QUO_W+1];
    logic              near_reg [QUO_W+1];
    logic              over_reg [QUO_W+1];
    logic [VAL_W-1:0]  base_reg [QUO_W+1];
    logic [63:0]       uc_reg   [QUO_W+1];
    logic [TW-1:0]     rem_reg  [QUO_W+1];
    logic [QUO_W-1:0]  quo_reg  [QUO_W+1];
    logic [TW-1:0]     rem_next [QUO_W+1];
    logic [QUO_W-1:0]  quo_next [QUO_W+1];
    sctu_res_t         res_reg;
    sctu_res_t         res_next;

    logic [63:0]       s_val, c_val, us, uc;
    logic [VAL_W-1:0]  base_next;

    function automatic logic [VAL_W-1:0] to_res(logic [63:0] v);
        logic [63:0] mg;
        logic [63:0] sh;
        mg = v[63] ? -v : v;
        sh = mg >> (SER_FB - RESULT_FRAC_BITS);
        return v[63] ? -sh[VAL_W-1:0] : sh[VAL_W-1:0];
    endfunction

    always_comb begin
        logic [TW-1:0] cand;
        s_val = in_ser.lane[LANE_SIN].sum;
        c_val = in_ser.lane[LANE_COS].sum;
        us    = s_val[63] ? -s_val : s_val;
        uc    = c_val[63] ? -c_val : c_val;
        unique case (in_ser.op)
            OP_SIN:  base_next = to_res(s_val);
            OP_COS:  base_next = to_res(c_val);
            default: base_next = '0;
        endcase
        rem_next[0] = TW'(us) << RESULT_FRAC_BITS;
        quo_next[0] = '0;
        for (int j = 1; j <= QUO_W; j++) begin
            cand = TW'(uc_reg[j-1]) << (QUO_W - j);
            if (rem_reg[j-1] >= cand) begin
                rem_next[j] = rem_reg[j-1] - cand;
                quo_next[j] = quo_reg[j-1] | (QUO_W'(1) << (QUO_W - j));
            end else begin
                rem_next[j] = rem_reg[j-1];
                quo_next[j] = quo_reg[j-1];
            end
        end
    end

    always_comb begin
        res_next.value = base_reg[QUO_W];
        res_next.sat   = 1'b0;
        if (op_reg[QUO_W] == OP_TAN) begin
            priority if (near_reg[QUO_W]) begin
                res_next.value = VAL_MAX;
                res_next.sat   = 1'b1;
            end else if (over_reg[QUO_W]) begin
                res_next.value = neg_reg[QUO_W] ? VAL_MIN : VAL_MAX;
                res_next.sat   = 1'b1;
            end else begin
                res_next.value = neg_reg[QUO_W] ? -{1'b0, quo_reg[QUO_W]}
                                                : {1'b0, quo_reg[QUO_W]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[QUO_W:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            op_reg[0]   <= in_ser.op;
            neg_reg[0]  <= s_val[63] != c_val[63];
            near_reg[0] <= uc < COS_EPS;
            // quotient would not fit in the result magnitude
            over_reg[0] <= (TW'(us) << RESULT_FRAC_BITS) >= (TW'(uc) << QUO_W);
            base_reg[0] <= base_next;
            uc_reg[0]   <= uc;
            rem_reg[0]  <= rem_next[0];
            quo_reg[0]  <= quo_next[0];
            for (int j = 1; j <= QUO_W; j++) begin
                op_reg[j]   <= op_reg[j-1];
                neg_reg[j]  <= neg_reg[j-1];
                near_reg[j] <= near_reg[j-1];
                over_reg[j] <= over_reg[j-1];
                base_reg[j] <= base_reg[j-1];
                uc_reg[j]   <= uc_reg[j-1];
                rem_reg[j]  <= rem_next[j];
                quo_reg[j]  <= quo_next[j];
            end
            res_reg <= res_next;
        end
    end

    assign out_valid = v_reg[QUO_W+1];
    assign out_res   = res_reg;

endmodule

### rtl/core/sine_cosine_tangent_unit_core.sv
// ----------------------------------------------------------------------------
// sine_cosine_tangent_unit_core
// Streaming sine, cosine and tangent of a fixed-point angle.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle while the pipe is not frozen by a
// blocked result, set by the term stages of the series lanes and the
// one-bit-per-stage reduction and tangent quotient.
// Reset: synchronous active-low aresetn clears all valid bits; data
// registers are not reset.
module sine_cosine_tangent_unit_core #(
    parameter int SERIES_TERMS     = sctu_pkg::SERIES_TERMS_DEF,
    parameter int ANGLE_FRAC_BITS  = sctu_pkg::ANGLE_FRAC_DEF,
    parameter int RESULT_FRAC_BITS = sctu_pkg::RESULT_FRAC_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] angle
    input  logic [1:0]  s_tuser,   // [1:0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [47:0] value
    output logic [0:0]  m_tuser    // [0] saturated
);
    import sctu_pkg::*;

    logic       adv;
    logic       red_valid, ser_valid, last_valid;
    logic [OP_W-1:0] red_op;
    logic signed [63:0] red_x;
    sctu_ser_t  ser_out;
    sctu_res_t  last_res;
    logic       out_valid_reg;
    sctu_res_t  out_res_reg;

    // freeze the whole pipe only when a finished result cannot move on
    assign adv      = !last_valid || !out_valid_reg || m_tready;
    assign s_tready = adv;

    sctu_reduce #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_reduce (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_tvalid),
        .in_op     (s_tuser),
        .in_angle  ($signed(s_tdata)),
        .out_valid (red_valid),
        .out_op    (red_op),
        .out_x     (red_x)
    );

    sctu_series #(
        .SERIES_TERMS (SERIES_TERMS)
    ) u_series (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (red_valid),
        .in_op     (red_op),
        .in_x      (red_x),
        .out_valid (ser_valid),
        .out_ser   (ser_out)
    );

    sctu_tan #(
        .RESULT_FRAC_BITS (RESULT_FRAC_BITS)
    ) u_tan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (ser_valid),
        .in_ser    (ser_out),
        .out_valid (last_valid),
        .out_res   (last_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_tready) begin
            out_valid_reg <= last_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_tready) begin
            out_res_reg <= last_res;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_res_reg.value;
    assign m_tuser[0] = out_res_reg.sat;

    a_empty_out_takes: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with an empty output register");

    a_sat_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tdata == VAL_MAX || m_tdata == VAL_MIN))
        else $error("saturated flag without a saturated value");

    a_stall_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready && last_valid |-> !s_tready)
        else $error("pipe advanced while a result was blocked");

endmodule

### dv/tb_sine_cosine_tangent_unit_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sine_cosine_tangent_unit_core
// Streams sine, cosine and tangent requests through the core and checks each
// result against a bit-exact fixed-point predictor kept in a queue.
// ----------------------------------------------------------------------------
module tb_sine_cosine_tangent_unit_core;
    import sctu_pkg::*;

    localparam int LATENCY  = 83 + 6 * SERIES_TERMS_DEF - ANGLE_FRAC_DEF;
    localparam int WDOG_MAX = 20000;
    localparam logic [1:0] OP_NONE = 2'd3;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [0:0]  m_tuser;

    sctu_res_t trig_expected[$];
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        recv_hold     = 0;
    int        mismatches    = 0;
    int        wdog          = 0;

    always #5 aclk = ~aclk;

    sine_cosine_tangent_unit_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    // truncated-magnitude Q.56 product with sign applied afterwards
    function automatic logic signed [63:0] q56_mul(logic signed [63:0] a,
                                                   logic signed [63:0] b);
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [127:0] p;
        logic [63:0]  r;
        ua = a[63] ? -a : a;
        ub = b[63] ? -b : b;
        p  = ua * ub;
        r  = {1'b0, p[118:56]};
        return (a[63] != b[63]) ? -r : r;
    endfunction

    function automatic logic signed [63:0] taylor_sum(logic signed [63:0] x, bit is_cos);
        logic signed [63:0] x2;
        logic signed [63:0] term;
        logic signed [63:0] sum;
        logic signed [63:0] d;
        x2   = q56_mul(x, x);
        term = is_cos ? (64'sd1 <<< SER_FB) : x;
        sum  = term;
        for (int n = 1; n <= SERIES_TERMS_DEF; n++) begin
            d    = is_cos ? (2 * n - 1) * (2 * n) : (2 * n) * (2 * n + 1);
            term = q56_mul(term, x2);
            term = -(term / d);
            sum  = sum + term;
        end
        return sum;
    endfunction

    function automatic logic [47:0] to_q30(logic signed [63:0] v);
        logic [63:0] m;
        m = (v[63] ? -v : v) >> (SER_FB - RESULT_FRAC_DEF);
        return v[63] ? 48'(-m) : 48'(m);
    endfunction

    function automatic sctu_res_t predict_trig(logic [1:0] op, logic signed [31:0] angle);
        sctu_res_t          res;
        logic signed [63:0] xw;
        logic signed [63:0] r;
        logic signed [63:0] x;
        logic signed [63:0] s;
        logic signed [63:0] c;
        logic [63:0]        m;
        logic [63:0]        us;
        logic [63:0]        uc;
        logic [127:0]       quo;
        bit                 neg;
        res = '0;
        xw  = 64'(angle) <<< (RED_FB - ANGLE_FRAC_DEF);
        m   = xw[63] ? -xw : xw;
        m   = m % 64'(TWO_PI_RED);
        r   = xw[63] ? -m : m;
        if (r > $signed(64'(PI_RED))) r = r - $signed(64'(TWO_PI_RED));
        if (r < -$signed(64'(PI_RED))) r = r + $signed(64'(TWO_PI_RED));
        x = r <<< (SER_FB - RED_FB);
        case (op)
            OP_SIN: res.value = to_q30(taylor_sum(x, 1'b0));
            OP_COS: res.value = to_q30(taylor_sum(x, 1'b1));
            OP_TAN: begin
                s  = taylor_sum(x, 1'b0);
                c  = taylor_sum(x, 1'b1);
                us = s[63] ? -s : s;
                uc = c[63] ? -c : c;
                if (uc < COS_EPS) begin
                    res.value = VAL_MAX;
                    res.sat   = 1'b1;
                end else begin
                    neg = s[63] != c[63];
                    quo = ({64'h0, us} << RESULT_FRAC_DEF) / {64'h0, uc};
                    if (quo > 128'(VAL_MAX)) begin
                        res.value = neg ? VAL_MIN : VAL_MAX;
                        res.sat   = 1'b1;
                    end else begin
                        res.value = neg ? 48'(-quo[47:0]) : quo[47:0];
                    end
                end
            end
            default: res = '0;
        endcase
        return res;
    endfunction

    task automatic send_trig(logic [1:0] op, logic [31:0] angle);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= angle;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        trig_expected.push_back(predict_trig(op, angle));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (trig_expected.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_angle();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 2 * 411775)) - 411775);
            2: return 32'($signed($urandom_range(0, 2000)) - 1000 + 102944);
            default: return 32'($signed($urandom_range(0, 2000)) - 1000 + 308831);
        endcase
    endfunction

    task automatic test_directed();
        logic [31:0] corners[8];
        corners = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_921F,
                    32'hFFFE_6DE1, 32'h0003_243F, 32'h0000_0001, 32'hFFFF_FFFF};
        foreach (corners[i]) begin
            send_trig(OP_SIN, corners[i]);
            send_trig(OP_COS, corners[i]);
            send_trig(OP_TAN, corners[i]);
        end
        send_trig(OP_NONE, 32'h1234_5678);
        // cosine close to zero, so the quotient overflows, around pi/2 and 3*pi/2
        send_trig(OP_TAN, 32'h0001_9220);
        send_trig(OP_TAN, 32'h0004_B65F);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_trig(($urandom_range(15) == 0) ? OP_NONE : 2'($urandom_range(2)),
                      rand_angle());
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_hold     = 400;
        test_random(300);
        drain_results();
    endtask

    always @(posedge aclk) begin
        if (recv_hold > 0) begin
            recv_hold <= recv_hold - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        sctu_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (trig_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", m_tdata);
            end else begin
                want = trig_expected.pop_front();
                if (m_tdata !== want.value || m_tuser[0] !== want.sat) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h/%b actual %h/%b",
                                 want.value, want.sat, m_tdata, m_tuser[0]);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) wdog <= 0;
        else wdog <= wdog + 1;
        if (wdog >= WDOG_MAX) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_idle_pct = 31;
        recv_idle_pct = 64;
        test_directed();
        drain_results();
        test_random(150);
        send_idle_pct = 64;
        recv_idle_pct = 31;
        test_random(150);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(150);
        test_backpressure();
        repeat (LATENCY + 20) @(posedge aclk);
        if (mismatches == 0 && trig_expected.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
